@@ design/bzt_pkg.sv @@
package bzt_pkg;

  localparam int CW        = 16;
  localparam int SC_W      = 6;
  localparam int FRAC      = 16;
  localparam int T_W       = FRAC + 1;
  localparam int A_W       = CW + T_W;
  localparam int D_W       = A_W + 1;
  localparam int S_W       = A_W + T_W;
  localparam int Q_W       = S_W - 2 * FRAC;
  localparam int REM_W     = SC_W;
  localparam int DIV_CNT_W = 5;
  localparam int IN_W      = ((9 * CW + SC_W + 7) / 8) * 8;
  localparam int OUT_W     = 3 * CW;

  localparam logic [SC_W-1:0]      MAX_STEPS  = SC_W'(63);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST   = DIV_CNT_W'(FRAC);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RUN
  } seq_state_t;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

@@ design/bzt_seq.sv @@
module bzt_seq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [bzt_pkg::SC_W-1:0] step_count,
  input  logic                     adv,
  output bzt_pkg::ctl_t            issue,
  output logic [bzt_pkg::T_W-1:0]  t_out
);
  import bzt_pkg::*;

  seq_state_t           state_r, state_nxt;
  logic [SC_W-1:0]      n_r, n_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [T_W-1:0]       q_r, q_nxt;
  logic [SC_W-1:0]      k_r, k_nxt;
  logic [T_W-1:0]       t_r, t_nxt;
  logic [REM_W-1:0]     r_r, r_nxt;

  logic [SC_W-1:0]      n_clamp;
  logic [REM_W:0]       rem_sh;
  logic                 q_bit;
  logic [REM_W:0]       r_sum;
  logic                 r_ge;

  // step count of zero behaves as one
  always_comb begin
    n_clamp = (step_count == '0) ? SC_W'(1) : step_count;
    if (n_clamp > MAX_STEPS) begin
      n_clamp = MAX_STEPS;
    end
  end

  // restoring division of 2^FRAC by n, one quotient bit a cycle
  assign rem_sh = {rem_r, cnt_r == DIV_LAST};
  assign q_bit  = rem_sh >= {1'b0, n_r};

  // t advances by 2^FRAC/n with the remainder carried
  assign r_sum = {1'b0, r_r} + {1'b0, rem_r};
  assign r_ge  = r_sum >= {1'b0, n_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    n_r   <= n_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    k_r   <= k_nxt;
    t_r   <= t_nxt;
    r_r   <= r_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    q_nxt       = q_r;
    k_nxt       = k_r;
    t_nxt       = t_r;
    r_nxt       = r_r;
    in_tready   = 1'b0;
    issue.valid = 1'b0;
    issue.last  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // no beat is taken while reset is held
        in_tready = rst_n;
        if (in_tvalid && in_tready) begin
          n_nxt     = n_clamp;
          cnt_nxt   = DIV_LAST;
          rem_nxt   = '0;
          q_nxt     = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = q_bit ? REM_W'(rem_sh - {1'b0, n_r}) : REM_W'(rem_sh);
        q_nxt   = {q_r[T_W-2:0], q_bit};
        cnt_nxt = cnt_r - DIV_CNT_W'(1);
        if (cnt_r == '0) begin
          k_nxt     = '0;
          t_nxt     = '0;
          r_nxt     = REM_W'(n_r >> 1);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        issue.valid = adv;
        issue.last  = k_r == n_r;
        if (adv) begin
          k_nxt = k_r + SC_W'(1);
          r_nxt = r_ge ? REM_W'(r_sum - {1'b0, n_r}) : REM_W'(r_sum);
          t_nxt = t_r + q_r + T_W'(r_ge);
          if (k_r == n_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign t_out = t_r;

endmodule

@@ design/bzt_lane.sv @@
module bzt_lane (
  input  logic                           clk,
  input  logic                           en,
  input  logic [bzt_pkg::T_W-1:0]        t_in,
  input  logic signed [bzt_pkg::CW-1:0]  p0,
  input  logic signed [bzt_pkg::CW-1:0]  p1,
  input  logic signed [bzt_pkg::CW-1:0]  p2,
  output logic signed [bzt_pkg::CW-1:0]  coord
);
  import bzt_pkg::*;

  localparam logic signed [Q_W-1:0] Q_HI = Q_W'((2 ** (CW - 1)) - 1);
  localparam logic signed [Q_W-1:0] Q_LO = -Q_HI - Q_W'(1);

  logic signed [CW:0]        d01, d12;
  logic signed [T_W:0]       ts1, ts3;
  logic signed [T_W+CW:0]    m01, m12;
  logic signed [A_W-1:0]     a_r, a_nxt, b_r, b_nxt, a2_r;
  logic [T_W-1:0]            t1_r, t2_r;
  logic signed [D_W-1:0]     d_r, d_nxt;
  logic signed [T_W+D_W-1:0] m_s;
  logic signed [S_W-1:0]     s_r, s_nxt;
  logic signed [S_W-1:0]     s_rnd;
  logic signed [Q_W-1:0]     q;

  // stage 1: A = P0 + t(P1-P0), B = P1 + t(P2-P1), scaled by 2^FRAC
  assign d01   = (CW+1)'(p1) - (CW+1)'(p0);
  assign d12   = (CW+1)'(p2) - (CW+1)'(p1);
  assign ts1   = $signed({1'b0, t_in});
  assign m01   = ts1 * d01;
  assign m12   = ts1 * d12;
  assign a_nxt = A_W'(m01) + (A_W'(p0) <<< FRAC);
  assign b_nxt = A_W'(m12) + (A_W'(p1) <<< FRAC);

  // stage 2
  assign d_nxt = D_W'(b_r) - D_W'(a_r);

  // stage 3: S = A + t(B-A), scaled by 2^(2*FRAC)
  assign ts3   = $signed({1'b0, t2_r});
  assign m_s   = ts3 * d_r;
  assign s_nxt = S_W'(m_s) + (S_W'(a2_r) <<< FRAC);

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      t1_r <= t_in;
      d_r  <= d_nxt;
      a2_r <= a_r;
      t2_r <= t1_r;
      s_r  <= s_nxt;
    end
  end

  // round half up, then saturate
  assign s_rnd = s_r + (S_W'(1) <<< (2 * FRAC - 1));
  assign q     = s_rnd[S_W-1:2*FRAC];

  always_comb begin
    if (q > Q_HI) begin
      coord = CW'(Q_HI);
    end else if (q < Q_LO) begin
      coord = CW'(Q_LO);
    end else begin
      coord = CW'(q);
    end
  end

endmodule

@@ design/bzt_merge.sv @@
module bzt_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bzt_pkg::ctl_t                 ctl,
  input  logic signed [bzt_pkg::CW-1:0] vx,
  input  logic signed [bzt_pkg::CW-1:0] vy,
  input  logic signed [bzt_pkg::CW-1:0] vz,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bzt_pkg::OUT_W-1:0]     out_tdata,
  output logic                          out_tlast,
  output logic                          adv
);
  import bzt_pkg::*;

  logic             valid_r;
  logic             last_r;
  logic [OUT_W-1:0] data_r;

  assign adv = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= ctl.valid;
    end
    if (adv) begin
      last_r <= ctl.last;
      data_r <= {vz, vy, vx};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = data_r;

endmodule

@@ design/quadratic_bezier_tessellator.sv @@
// Quadratic Bezier tessellator.
// Slave side (in_*): one beat carries control points P0, P1, P2 (signed Q7.8)
// and a step count n; the block is busy until every vertex of the beat has
// been started, with in_tready low in that time.
// Master side (out_*): n+1 vertex beats, P0 first and P2 last, the last one
// with out_tlast high. A step count of zero is taken as one.
// Path to the first vertex beat: bit-serial division of 2^16 by n, then a
// three-stage blend pipeline per coordinate and the output register.
// Throughput: one vertex beat per cycle while a run streams and the receiver
// does not stall. The next input beat is taken as soon as the last vertex
// has entered the pipeline.
// Reset (synchronous, active low) empties the pipeline and the output
// register and returns the sequencer to idle; no beat is pending after it.
// When the receiver stalls, the output register holds its beat and the whole
// blend pipeline and the sequencer's vertex issue freeze until it is taken.
module quadratic_bezier_tessellator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, step_count, zero pad
  input  logic [bzt_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // vx, vy, vz
  output logic [bzt_pkg::OUT_W-1:0]   out_tdata,
  output logic                        out_tlast
);
  import bzt_pkg::*;

  logic signed [CW-1:0] p_r [9];
  logic                 adv;
  logic                 in_beat;
  ctl_t                 issue, c1_r, c2_r, c3_r;
  logic [T_W-1:0]       t_cur;
  logic signed [CW-1:0] vx, vy, vz;

  assign in_beat = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_beat) begin
      for (int i = 0; i < 9; i++) begin
        p_r[i] <= in_tdata[i*CW +: CW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
    end else if (adv) begin
      c1_r <= issue;
      c2_r <= c1_r;
      c3_r <= c2_r;
    end
  end

  bzt_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .step_count (in_tdata[9*CW +: SC_W]),
    .adv        (adv),
    .issue      (issue),
    .t_out      (t_cur)
  );

  bzt_lane u_lane_x (
    .clk   (clk),
    .en    (adv),
    .t_in  (t_cur),
    .p0    (p_r[0]),
    .p1    (p_r[3]),
    .p2    (p_r[6]),
    .coord (vx)
  );

  bzt_lane u_lane_y (
    .clk   (clk),
    .en    (adv),
    .t_in  (t_cur),
    .p0    (p_r[1]),
    .p1    (p_r[4]),
    .p2    (p_r[7]),
    .coord (vy)
  );

  bzt_lane u_lane_z (
    .clk   (clk),
    .en    (adv),
    .t_in  (t_cur),
    .p0    (p_r[2]),
    .p1    (p_r[5]),
    .p2    (p_r[8]),
    .coord (vz)
  );

  bzt_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (c3_r),
    .vx         (vx),
    .vy         (vy),
    .vz         (vz),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .adv        (adv)
  );

endmodule

@@ design/bzt_chk.sv @@
module bzt_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [bzt_pkg::OUT_W-1:0] out_tdata,
  input logic                      out_tlast
);

  // stalled beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("out beat changed while stalled");

  // busy after taking an item
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second input beat taken before the first was divided");

  // reset empties the output
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output beat present after reset");

endmodule

bind quadratic_bezier_tessellator bzt_chk u_bzt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
